FILE: sv/pfs_pkg.sv
// Shared types and constants of the printf conversion specification parser.
`timescale 1ns / 1ps

package pfs_pkg;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 80;
	localparam int CHAR_W    = 8;
	localparam int ARG_W     = 32;
	localparam int MAG_W     = 31;
	localparam int FW_W      = 31;
	localparam int PREC_W    = 32;
	localparam int LMOD_W    = 3;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_H     = 8'h68;
	localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
	localparam logic [CHAR_W-1:0] CH_BIGL  = 8'h4C;
	localparam logic [CHAR_W-1:0] CH_J     = 8'h6A;
	localparam logic [CHAR_W-1:0] CH_Z     = 8'h7A;

	// length modifier codes
	localparam logic [LMOD_W-1:0] LM_NONE = 3'd0;
	localparam logic [LMOD_W-1:0] LM_HH   = 3'd1;
	localparam logic [LMOD_W-1:0] LM_H    = 3'd2;
	localparam logic [LMOD_W-1:0] LM_L    = 3'd3;
	localparam logic [LMOD_W-1:0] LM_LL   = 3'd4;
	localparam logic [LMOD_W-1:0] LM_J    = 3'd5;
	localparam logic [LMOD_W-1:0] LM_Z    = 3'd6;
	localparam logic [LMOD_W-1:0] LM_BIGL = 3'd7;

	typedef enum logic [3:0] {
		C_MINUS, C_PLUS, C_SPACE, C_HASH, C_ZERO, C_DIGIT, C_STAR, C_DOT,
		C_H, C_L, C_J, C_Z, C_BIGL, C_OTHER
	} cls_t;

	typedef struct packed {
		logic             start;
		cls_t             cls;
		logic             is_digit;
		logic [3:0]       digit;
		logic             star_neg;
		logic [MAG_W-1:0] star_mag;  // magnitude, already saturated
	} item_t;

endpackage

FILE: sv/printf_format_spec_parser.sv
// Top level of the printf conversion specification parser.
`timescale 1ns / 1ps
//
// Feed the characters after a '%' one word per cycle on the s_ channel; set
// s_tuser on the first of them to clear the parse state. Each input word
// gives exactly one result word on the m_ channel: whether the character was
// consumed, whether the specifier has ended (that character is then the
// conversion), the flags, field width, precision (all ones for none) and
// length modifier as they stand after the character.
// Results are registered: an accepted word passes through the queue and then
// the result register, and a receiver stall can hold it in between. Throughput
// is one word per cycle while the receiver keeps up, set by the parse step
// (phase decode plus one saturating multiply-by-ten and add) in the back end.
// The front end classifies characters and saturates star arguments into a
// two-entry queue; the back end pops it whenever its result register is free
// or being taken. When the receiver stalls the result is held, the queue
// fills and s_tready drops once both entries are full.
// Reset empties the queue, drops m_tvalid and puts the parser into the flags
// phase with no precision and no modifier.

module printf_format_spec_parser #(
	parameter int COUNT_BITS = 31
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [7:0] character, [39:8] star_arg
	input  logic [pfs_pkg::S_TDATA_W-1:0]     s_tdata,
	// [0] start_req
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] consumed, [1] done_res, [2] left_align, [3] force_sign,
	// [4] space_sign, [5] zero_pad, [6] alt_form, [37:7] field_width,
	// [69:38] precision, [72:70] length_mod, [79:73] zero
	output logic [pfs_pkg::M_TDATA_W-1:0]     m_tdata
);
	import pfs_pkg::*;

	item_t head;
	logic  head_valid;
	logic  head_pop;

	// classify and queue
	pfs_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.start      (s_tuser),
		.chr        (s_tdata[CHAR_W-1:0]),
		.arg        (s_tdata[CHAR_W+ARG_W-1:CHAR_W]),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head       (head)
	);

	// advance the parse state and hold the result word
	pfs_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head       (head),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule

FILE: sv/pfs_front.sv
// Front end: classifies each incoming character and queues it for the back end.
`timescale 1ns / 1ps

module pfs_front #(
	parameter int COUNT_BITS = 31
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           start,
	input  logic [pfs_pkg::CHAR_W-1:0]     chr,
	input  logic [pfs_pkg::ARG_W-1:0]      arg,
	output logic                           head_valid,
	input  logic                           head_pop,
	output pfs_pkg::item_t                 head
);
	import pfs_pkg::*;

	localparam int DEPTH = 2;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PTR_W = $clog2(DEPTH);

	item_t                  cls_item;
	logic [ARG_W-1:0]       mag;
	logic [COUNT_BITS-1:0]  mag_sat;
	item_t                  mem_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   push;
	logic                   pop;

	// star argument magnitude; the most negative value gives 2^31
	assign mag     = arg[ARG_W-1] ? (~arg + ARG_W'(1)) : arg;
	assign mag_sat = (mag[ARG_W-1:COUNT_BITS] != '0) ? '1 : mag[COUNT_BITS-1:0];

	always_comb begin
		cls_item.start    = start;
		cls_item.is_digit = (chr >= CH_ZERO) && (chr <= CH_NINE);
		cls_item.digit    = 4'(chr - CH_ZERO);
		cls_item.star_neg = arg[ARG_W-1];
		cls_item.star_mag = MAG_W'(mag_sat);
		if (chr == CH_MINUS)          cls_item.cls = C_MINUS;
		else if (chr == CH_PLUS)      cls_item.cls = C_PLUS;
		else if (chr == CH_SPACE)     cls_item.cls = C_SPACE;
		else if (chr == CH_HASH)      cls_item.cls = C_HASH;
		else if (chr == CH_ZERO)      cls_item.cls = C_ZERO;
		else if (cls_item.is_digit)   cls_item.cls = C_DIGIT;
		else if (chr == CH_STAR)      cls_item.cls = C_STAR;
		else if (chr == CH_DOT)       cls_item.cls = C_DOT;
		else if (chr == CH_H)         cls_item.cls = C_H;
		else if (chr == CH_L)         cls_item.cls = C_L;
		else if (chr == CH_J)         cls_item.cls = C_J;
		else if (chr == CH_Z)         cls_item.cls = C_Z;
		else if (chr == CH_BIGL)      cls_item.cls = C_BIGL;
		else                          cls_item.cls = C_OTHER;
	end

	assign in_ready   = (count_q != CNT_W'(DEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != '0);
	assign pop        = head_pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

FILE: sv/pfs_back.sv
// Back end: parse state machine and registered result word.
`timescale 1ns / 1ps

module pfs_back #(
	parameter int COUNT_BITS = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	output logic                            head_pop,
	input  pfs_pkg::item_t                  head,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pfs_pkg::M_TDATA_W-1:0]   out_data
);
	import pfs_pkg::*;

	localparam int ACC_W = COUNT_BITS + 4;

	typedef enum logic [3:0] {
		PH_FLAGS, PH_WDIG, PH_WSTAR, PH_PSTART, PH_PDIG, PH_PSTAR,
		PH_MOD_H, PH_MOD_L, PH_MOD_LL, PH_MOD_JZL, PH_END
	} phase_t;

	// flag bit positions
	localparam int FB_MINUS = 0;
	localparam int FB_PLUS  = 1;
	localparam int FB_SPACE = 2;
	localparam int FB_ZERO  = 3;
	localparam int FB_HASH  = 4;

	phase_t                 phase_q, phase_d, cur_phase, mod_phase;
	logic [4:0]             flags_q, flags_d, cur_flags;
	logic [COUNT_BITS-1:0]  width_q, width_d, cur_width;
	logic                   pnone_q, pnone_d, cur_pnone;
	logic [COUNT_BITS-1:0]  pval_q, pval_d, cur_pval;
	logic [LMOD_W-1:0]      lmod_q, lmod_d, cur_lmod, mod_code;
	logic                   consumed_q, took, mod_took;
	logic                   out_valid_q;
	logic [2:0]             lvl;
	logic [COUNT_BITS-1:0]  acc_base, acc_sat, star_val;
	logic [ACC_W-1:0]       acc_full;
	logic [PREC_W-1:0]      prec_out;

	assign head_pop = head_valid && (!out_valid_q || out_ready);
	assign star_val = head.star_mag[COUNT_BITS-1:0];

	// start of a new specifier clears the parse state first
	always_comb begin
		if (head.start) begin
			cur_phase = PH_FLAGS;
			cur_flags = '0;
			cur_width = '0;
			cur_pnone = 1'b1;
			cur_pval  = '0;
			cur_lmod  = LM_NONE;
		end else begin
			cur_phase = phase_q;
			cur_flags = flags_q;
			cur_width = width_q;
			cur_pnone = pnone_q;
			cur_pval  = pval_q;
			cur_lmod  = lmod_q;
		end
	end

	// decimal accumulate: base * 10 + digit, saturating
	always_comb begin
		case (cur_phase)
			PH_WDIG: acc_base = cur_width;
			PH_PDIG: acc_base = cur_pval;
			default: acc_base = '0;
		endcase
		acc_full = ACC_W'({acc_base, 3'b000}) + ACC_W'({acc_base, 1'b0})
			+ ACC_W'(head.digit);
		acc_sat  = (acc_full[ACC_W-1:COUNT_BITS] != '0) ? '1 : acc_full[COUNT_BITS-1:0];
	end

	// length modifier chain
	always_comb begin
		case (cur_phase)
			PH_MOD_H:   lvl = 3'd1;
			PH_MOD_L:   lvl = 3'd2;
			PH_MOD_LL:  lvl = 3'd3;
			PH_MOD_JZL: lvl = 3'd4;
			default:    lvl = 3'd0;
		endcase
		mod_took  = 1'b1;
		mod_code  = cur_lmod;
		mod_phase = PH_END;
		if (lvl == 3'd0 && head.cls == C_H) begin
			mod_code  = LM_H;
			mod_phase = PH_MOD_H;
		end else if (lvl == 3'd1 && head.cls == C_H) begin
			mod_code  = LM_HH;
			mod_phase = PH_MOD_L;
		end else if (lvl <= 3'd2 && head.cls == C_L) begin
			mod_code  = LM_L;
			mod_phase = PH_MOD_LL;
		end else if (lvl == 3'd3 && head.cls == C_L) begin
			mod_code  = LM_LL;
			mod_phase = PH_MOD_JZL;
		end else if (head.cls == C_J) begin
			mod_code = LM_J;
		end else if (head.cls == C_Z) begin
			mod_code = LM_Z;
		end else if (head.cls == C_BIGL) begin
			mod_code = LM_BIGL;
		end else begin
			mod_took = 1'b0;
		end
	end

	always_comb begin
		phase_d = cur_phase;
		flags_d = cur_flags;
		width_d = cur_width;
		pnone_d = cur_pnone;
		pval_d  = cur_pval;
		lmod_d  = cur_lmod;
		took    = 1'b0;
		case (cur_phase)
			PH_FLAGS, PH_WDIG, PH_WSTAR: begin
				if (cur_phase == PH_FLAGS && head.cls == C_MINUS) begin
					flags_d[FB_MINUS] = 1'b1;
					took = 1'b1;
				end else if (cur_phase == PH_FLAGS && head.cls == C_PLUS) begin
					flags_d[FB_PLUS] = 1'b1;
					took = 1'b1;
				end else if (cur_phase == PH_FLAGS && head.cls == C_SPACE) begin
					flags_d[FB_SPACE] = 1'b1;
					took = 1'b1;
				end else if (cur_phase == PH_FLAGS && head.cls == C_HASH) begin
					flags_d[FB_HASH] = 1'b1;
					took = 1'b1;
				end else if (cur_phase == PH_FLAGS && head.cls == C_ZERO) begin
					flags_d[FB_ZERO] = 1'b1;
					took = 1'b1;
				end else if (cur_phase != PH_WSTAR && head.is_digit) begin
					width_d = acc_sat;
					phase_d = PH_WDIG;
					took    = 1'b1;
				end else if (cur_phase == PH_FLAGS && head.cls == C_STAR) begin
					if (head.star_neg) begin
						flags_d[FB_MINUS] = 1'b1;
					end
					width_d = star_val;
					phase_d = PH_WSTAR;
					took    = 1'b1;
				end else if (head.cls == C_DOT) begin
					pnone_d = 1'b0;
					pval_d  = '0;
					phase_d = PH_PSTART;
					took    = 1'b1;
				end else begin
					lmod_d  = mod_code;
					phase_d = mod_phase;
					took    = mod_took;
				end
			end
			PH_PSTART, PH_PDIG, PH_PSTAR: begin
				if (cur_phase == PH_PSTART && head.cls == C_STAR) begin
					pnone_d = head.star_neg;
					pval_d  = head.star_neg ? '0 : star_val;
					phase_d = PH_PSTAR;
					took    = 1'b1;
				end else if (cur_phase != PH_PSTAR && head.is_digit) begin
					pval_d  = acc_sat;
					phase_d = PH_PDIG;
					took    = 1'b1;
				end else begin
					lmod_d  = mod_code;
					phase_d = mod_phase;
					took    = mod_took;
				end
			end
			PH_MOD_H, PH_MOD_L, PH_MOD_LL, PH_MOD_JZL: begin
				lmod_d  = mod_code;
				phase_d = mod_phase;
				took    = mod_took;
			end
			default: begin
				phase_d = PH_END;
				took    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FLAGS;
			flags_q     <= '0;
			width_q     <= '0;
			pnone_q     <= 1'b1;
			pval_q      <= '0;
			lmod_q      <= LM_NONE;
			consumed_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (head_pop) begin
				phase_q     <= phase_d;
				flags_q     <= flags_d;
				width_q     <= width_d;
				pnone_q     <= pnone_d;
				pval_q      <= pval_d;
				lmod_q      <= lmod_d;
				consumed_q  <= took;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign prec_out  = pnone_q ? '1 : PREC_W'(pval_q);
	assign out_valid = out_valid_q;
	assign out_data  = {7'b0, lmod_q, prec_out, FW_W'(width_q),
		flags_q[FB_HASH],
		flags_q[FB_ZERO] & ~flags_q[FB_MINUS],
		flags_q[FB_SPACE] & ~flags_q[FB_PLUS],
		flags_q[FB_PLUS],
		flags_q[FB_MINUS],
		~consumed_q,
		consumed_q};

endmodule
